// ===== sv/lbm_d2q9_cell_collision_core_macros.svh =====
// Assertion macros used by the checker file of the D2Q9 collision core.
`ifndef LBM_D2Q9_CELL_COLLISION_CORE_MACROS_SVH
`define LBM_D2Q9_CELL_COLLISION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D2Q9C_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in d2q9c checker");

// The consequent must hold in the cycle after the antecedent.
`define D2Q9C_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in d2q9c checker");

`endif

// ===== sv/d2q9c_pkg.sv =====
// Types, constants and helper functions of the D2Q9 collision core.
package d2q9c_pkg;

   localparam int NUM_DIRS    = 9;
   localparam int VAL_W       = 24;
   localparam int QBITS       = 24;
   localparam int RATE_W      = 22;
   localparam int MOM_STAGES  = 2;
   localparam int EQ_STAGES   = 4;
   localparam int RLX_STAGES  = 3;
   localparam int PIPE_STAGES = MOM_STAGES + QBITS + EQ_STAGES + RLX_STAGES;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [VAL_W-2:0]        rho_type;
   typedef logic [RATE_W-1:0]       rate_type;

   localparam val_type VAL_MAX = 24'sh7FFFFF;
   localparam val_type VAL_MIN = 24'sh800000;

   // Reciprocals of nine: exact floor for rho / 9 and for 4 * rho / 9.
   localparam logic [23:0] RECIP9_SMALL = 24'd14913081;
   localparam int          RECIP9_SMALL_SH = 27;
   localparam logic [25:0] RECIP9_WIDE  = 26'd59652324;
   localparam int          RECIP9_WIDE_SH = 29;

   typedef struct packed {
      val_type [NUM_DIRS-1:0] f;
      logic                   solid;
      rho_type                rho;
      val_type                ux;
      val_type                uy;
   } cell_type;

   typedef struct packed {
      logic             neg;
      logic             ov;
      logic [QBITS-1:0] rem;
      logic [QBITS-1:0] ql;
   } div_lane_type;

   typedef struct packed {
      val_type [NUM_DIRS-1:0] d;
      val_type                density;
      val_type                ux;
      val_type                uy;
   } result_type;

   function automatic val_type sat_val(input logic signed [63:0] v);
      val_type r;
      if (v > 64'sd8388607) begin
         r = VAL_MAX;
      end else if (v < -64'sd8388608) begin
         r = VAL_MIN;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   // One restoring step: brings down the next dividend bit and shifts in a quotient bit.
   function automatic div_lane_type div_step(input div_lane_type l, input rho_type rho);
      logic [QBITS:0] t;
      div_lane_type   r;
      r = l;
      t = {l.rem, l.ql[QBITS-1]};
      if (t >= {2'b00, rho}) begin
         r.rem = QBITS'(t - {2'b00, rho});
         r.ql  = {l.ql[QBITS-2:0], 1'b1};
      end else begin
         r.rem = t[QBITS-1:0];
         r.ql  = {l.ql[QBITS-2:0], 1'b0};
      end
      return r;
   endfunction

   function automatic val_type quot_to_val(input div_lane_type l);
      val_type r;
      if (l.ov) begin
         r = l.neg ? VAL_MIN : VAL_MAX;
      end else if (l.neg) begin
         r = (l.ql > 24'h800000) ? VAL_MIN : val_type'(24'd0 - l.ql);
      end else begin
         r = (l.ql > 24'h7FFFFF) ? VAL_MAX : val_type'(l.ql);
      end
      return r;
   endfunction

endpackage

// ===== sv/d2q9c_req_if.sv =====
// Input channel: nine distributions and the solid flag of one cell.
interface d2q9c_req_if import d2q9c_pkg::*; ();
   logic    valid;
   logic    ready;
   val_type dist_in_0;
   val_type dist_in_1;
   val_type dist_in_2;
   val_type dist_in_3;
   val_type dist_in_4;
   val_type dist_in_5;
   val_type dist_in_6;
   val_type dist_in_7;
   val_type dist_in_8;
   logic    solid;

   modport source (output valid, dist_in_0, dist_in_1, dist_in_2, dist_in_3, dist_in_4,
                   dist_in_5, dist_in_6, dist_in_7, dist_in_8, solid, input ready);
   modport sink (input valid, dist_in_0, dist_in_1, dist_in_2, dist_in_3, dist_in_4,
                 dist_in_5, dist_in_6, dist_in_7, dist_in_8, solid, output ready);
endinterface

// ===== sv/d2q9c_rsp_if.sv =====
// Result channel: post-collision distributions, density and velocity.
interface d2q9c_rsp_if import d2q9c_pkg::*; ();
   logic    valid;
   logic    ready;
   val_type dist_out_0;
   val_type dist_out_1;
   val_type dist_out_2;
   val_type dist_out_3;
   val_type dist_out_4;
   val_type dist_out_5;
   val_type dist_out_6;
   val_type dist_out_7;
   val_type dist_out_8;
   val_type density;
   val_type velocity_x;
   val_type velocity_y;

   modport source (output valid, dist_out_0, dist_out_1, dist_out_2, dist_out_3, dist_out_4,
                   dist_out_5, dist_out_6, dist_out_7, dist_out_8, density, velocity_x,
                   velocity_y, input ready);
   modport sink (input valid, dist_out_0, dist_out_1, dist_out_2, dist_out_3, dist_out_4,
                 dist_out_5, dist_out_6, dist_out_7, dist_out_8, density, velocity_x,
                 velocity_y, output ready);
endinterface

// ===== sv/d2q9c_csr_if.sv =====
// Configuration write channel carrying the relaxation rate.
interface d2q9c_csr_if import d2q9c_pkg::*; ();
   logic     valid;
   logic     ready;
   rate_type relax_rate;

   modport source (output valid, relax_rate, input ready);
   modport sink (input valid, relax_rate, output ready);
endinterface

// ===== sv/d2q9c_moments.sv =====
// Density and momentum sums, density floor and divider set-up.
module d2q9c_moments import d2q9c_pkg::*; #(
   parameter int FRAC_BITS
) (
   input  logic                  clock,
   input  logic [MOM_STAGES-1:0] load,
   input  cell_type              cell_in,
   output cell_type              cell_out,
   output div_lane_type          lane_x,
   output div_lane_type          lane_y
);

   localparam int SW  = 28;
   localparam int NXW = SW + FRAC_BITS;
   localparam int CW  = NXW + QBITS;
   localparam logic signed [SW-1:0] ONE_S  = 1;
   localparam logic signed [SW-1:0] VMAX_S = 8388607;

   cell_type              cell_a_ff, cell_b_ff, cell_b_in;
   logic signed [SW-1:0]  rsum_ff, rsum_in, mx_ff, mx_in, my_ff, my_in;
   div_lane_type          lx_ff, lx_in, ly_ff, ly_in;

   function automatic logic signed [SW-1:0] sx(input val_type v);
      return {{(SW-VAL_W){v[VAL_W-1]}}, v};
   endfunction

   function automatic div_lane_type lane_init(input logic signed [SW-1:0] m,
                                              input rho_type rho);
      logic [SW-1:0]  mag;
      logic [NXW-1:0] nx;
      div_lane_type   l;
      mag   = m[SW-1] ? $unsigned(-m) : $unsigned(m);
      nx    = {mag, {FRAC_BITS{1'b0}}};
      l.neg = m[SW-1];
      // A quotient of 2^24 or more saturates whatever its low bits.
      l.ov  = (CW'(nx) >= (CW'(rho) << QBITS));
      l.rem = l.ov ? '0 : QBITS'(nx >> QBITS);
      l.ql  = nx[QBITS-1:0];
      return l;
   endfunction

   always_comb begin
      rsum_in = '0;
      for (int k = 0; k < NUM_DIRS; k++) begin
         rsum_in = rsum_in + sx(cell_in.f[k]);
      end
      mx_in = sx(cell_in.f[1]) - sx(cell_in.f[3]) + sx(cell_in.f[5])
            - sx(cell_in.f[6]) - sx(cell_in.f[7]) + sx(cell_in.f[8]);
      my_in = sx(cell_in.f[2]) - sx(cell_in.f[4]) + sx(cell_in.f[5])
            + sx(cell_in.f[6]) - sx(cell_in.f[7]) - sx(cell_in.f[8]);
   end

   always_comb begin
      cell_b_in = cell_a_ff;
      if (rsum_ff < ONE_S) begin
         cell_b_in.rho = rho_type'(1);
      end else if (rsum_ff > VMAX_S) begin
         cell_b_in.rho = '1;
      end else begin
         cell_b_in.rho = rsum_ff[VAL_W-2:0];
      end
      lx_in = lane_init(mx_ff, cell_b_in.rho);
      ly_in = lane_init(my_ff, cell_b_in.rho);
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         cell_a_ff <= cell_in;
         rsum_ff   <= rsum_in;
         mx_ff     <= mx_in;
         my_ff     <= my_in;
      end
      if (load[1]) begin
         cell_b_ff <= cell_b_in;
         lx_ff     <= lx_in;
         ly_ff     <= ly_in;
      end
   end

   assign cell_out = cell_b_ff;
   assign lane_x   = lx_ff;
   assign lane_y   = ly_ff;

endmodule

// ===== sv/d2q9c_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage for both velocity lanes.
module d2q9c_divider import d2q9c_pkg::*; (
   input  logic             clock,
   input  logic [QBITS-1:0] load,
   input  cell_type         cell_in,
   input  div_lane_type     x_in,
   input  div_lane_type     y_in,
   output cell_type         cell_out,
   output div_lane_type     x_out,
   output div_lane_type     y_out
);

   cell_type     cell_ff [QBITS];
   div_lane_type x_ff    [QBITS];
   div_lane_type y_ff    [QBITS];

   for (genvar s = 0; s < QBITS; s++) begin : g_row
      cell_type     c_src;
      div_lane_type x_src, y_src;
      if (s == 0) begin : g_first
         assign c_src = cell_in;
         assign x_src = x_in;
         assign y_src = y_in;
      end else begin : g_next
         assign c_src = cell_ff[s-1];
         assign x_src = x_ff[s-1];
         assign y_src = y_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (load[s]) begin
            cell_ff[s] <= c_src;
            x_ff[s]    <= div_step(x_src, c_src.rho);
            y_ff[s]    <= div_step(y_src, c_src.rho);
         end
      end
   end

   assign cell_out = cell_ff[QBITS-1];
   assign x_out    = x_ff[QBITS-1];
   assign y_out    = y_ff[QBITS-1];

endmodule

// ===== sv/d2q9c_equilibrium.sv =====
// Velocity saturation, squares, weights and the split equilibrium products.
module d2q9c_equilibrium import d2q9c_pkg::*; #(
   parameter int FRAC_BITS
) (
   input  logic                              clock,
   input  logic [EQ_STAGES-1:0]              load,
   input  cell_type                          cell_in,
   input  div_lane_type                      x_in,
   input  div_lane_type                      y_in,
   output cell_type                          cell_out,
   output logic [NUM_DIRS-1:0][46:0]         lo_out,
   output logic [NUM_DIRS-1:0][FRAC_BITS+24:0] hi_out
);

   localparam int IW  = 60;
   localparam int PCW = FRAC_BITS + 25;
   localparam int HPW = FRAC_BITS + 25;
   localparam logic signed [IW-1:0] ONE  = 60'sd1 <<< FRAC_BITS;
   localparam logic signed [IW-1:0] PLIM = 60'sd1 <<< (23 + FRAC_BITS);

   // Stage 1: saturated velocity and reciprocal products for the weights.
   cell_type    c1_ff, c1_in;
   logic [46:0] w9p_ff, w9p_in;
   logic [50:0] w49p_ff, w49p_in;

   always_comb begin
      c1_in    = cell_in;
      c1_in.ux = quot_to_val(x_in);
      c1_in.uy = quot_to_val(y_in);
      w9p_in   = 47'(cell_in.rho) * 47'(RECIP9_SMALL);
      w49p_in  = 51'({cell_in.rho, 2'b00}) * 51'(RECIP9_WIDE);
   end

   // Stage 2: squares of the velocity combinations and the three weights.
   cell_type    c2_ff;
   logic [48:0] sqx_ff, sqx_in, sqy_ff, sqy_in, sqp_ff, sqp_in, sqm_ff, sqm_in;
   rho_type     wrest_ff, wrest_in, waxis_ff, waxis_in, wdiag_ff, wdiag_in;

   always_comb begin
      logic signed [48:0] ax, ay, ap, am;
      ax       = 49'(c1_ff.ux);
      ay       = 49'(c1_ff.uy);
      ap       = ax + ay;
      am       = ax - ay;
      sqx_in   = 49'(ax * ax);
      sqy_in   = 49'(ay * ay);
      sqp_in   = 49'(ap * ap);
      sqm_in   = 49'(am * am);
      waxis_in = rho_type'(w9p_ff[46:RECIP9_SMALL_SH]);
      wrest_in = rho_type'(w49p_ff[50:RECIP9_WIDE_SH]);
      wdiag_in = rho_type'(w9p_ff[46:RECIP9_SMALL_SH] >> 2);
   end

   // Stage 3: equilibrium polynomial per direction, clamped so that the
   // saturated product with a non-zero weight is unchanged.
   cell_type                       c3_ff;
   logic [NUM_DIRS-1:0][PCW-1:0]   p_ff, p_in;
   logic [NUM_DIRS-1:0][22:0]      wr_ff, wr_in;

   always_comb begin
      logic signed [IW-1:0] u2, t3, cu2, pv;
      logic signed [26:0]   cx, cy, cu;
      logic [48:0]          s;
      u2 = (IW'(sqx_ff) + IW'(sqy_ff)) >>> FRAC_BITS;
      t3 = (u2 + (u2 <<< 1)) >>> 1;
      cx = 27'(c2_ff.ux);
      cy = 27'(c2_ff.uy);
      for (int k = 0; k < NUM_DIRS; k++) begin
         case (k)
            1:       begin cu = cx;        s = sqx_ff; wr_in[k] = waxis_ff; end
            2:       begin cu = cy;        s = sqy_ff; wr_in[k] = waxis_ff; end
            3:       begin cu = -cx;       s = sqx_ff; wr_in[k] = waxis_ff; end
            4:       begin cu = -cy;       s = sqy_ff; wr_in[k] = waxis_ff; end
            5:       begin cu = cx + cy;   s = sqp_ff; wr_in[k] = wdiag_ff; end
            6:       begin cu = cy - cx;   s = sqm_ff; wr_in[k] = wdiag_ff; end
            7:       begin cu = -cx - cy;  s = sqp_ff; wr_in[k] = wdiag_ff; end
            8:       begin cu = cx - cy;   s = sqm_ff; wr_in[k] = wdiag_ff; end
            default: begin cu = '0;        s = '0;     wr_in[k] = wrest_ff; end
         endcase
         cu  = cu + (cu <<< 1);
         cu2 = ((IW'(s) <<< 3) + IW'(s)) >>> (FRAC_BITS + 1);
         pv  = ONE + IW'(cu) + cu2 - t3;
         if (pv > PLIM) begin
            pv = PLIM;
         end else if (pv < -PLIM) begin
            pv = -PLIM;
         end
         p_in[k] = pv[PCW-1:0];
      end
   end

   // Stage 4: weight times polynomial, cut into a low and a high partial product.
   cell_type                      c4_ff;
   logic [NUM_DIRS-1:0][46:0]     lo_ff, lo_in;
   logic [NUM_DIRS-1:0][HPW-1:0]  hi_ff, hi_in;

   always_comb begin
      logic signed [HPW-1:0] ws, ph;
      for (int k = 0; k < NUM_DIRS; k++) begin
         lo_in[k] = 47'(wr_ff[k]) * 47'(p_ff[k][23:0]);
         ws       = HPW'($signed({1'b0, wr_ff[k]}));
         ph       = HPW'($signed(p_ff[k][PCW-1:24]));
         hi_in[k] = ws * ph;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         c1_ff   <= c1_in;
         w9p_ff  <= w9p_in;
         w49p_ff <= w49p_in;
      end
      if (load[1]) begin
         c2_ff    <= c1_ff;
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         sqp_ff   <= sqp_in;
         sqm_ff   <= sqm_in;
         wrest_ff <= wrest_in;
         waxis_ff <= waxis_in;
         wdiag_ff <= wdiag_in;
      end
      if (load[2]) begin
         c3_ff <= c2_ff;
         p_ff  <= p_in;
         wr_ff <= wr_in;
      end
      if (load[3]) begin
         c4_ff <= c3_ff;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign cell_out = c4_ff;
   assign lo_out   = lo_ff;
   assign hi_out   = hi_ff;

endmodule

// ===== sv/d2q9c_relax.sv =====
// Equilibrium assembly, BGK relaxation and the output register.
module d2q9c_relax import d2q9c_pkg::*; #(
   parameter int FRAC_BITS
) (
   input  logic                                clock,
   input  logic [RLX_STAGES-1:0]               load,
   input  rate_type                            rate,
   input  cell_type                            cell_in,
   input  logic [NUM_DIRS-1:0][46:0]           lo_in,
   input  logic [NUM_DIRS-1:0][FRAC_BITS+24:0] hi_in,
   output result_type                          result
);

   localparam int FW = FRAC_BITS + 50;

   cell_type                   c5_ff, c6_ff;
   logic [NUM_DIRS-1:0][24:0]  diff_ff, diff_in;
   logic [NUM_DIRS-1:0][47:0]  d_ff, d_in;
   result_type                 res_ff, res_in;

   always_comb begin
      logic signed [FW-1:0] full;
      val_type              feq, fk;
      for (int k = 0; k < NUM_DIRS; k++) begin
         fk         = cell_in.f[k];
         full       = (FW'($signed(hi_in[k])) <<< 24) + FW'(lo_in[k]);
         feq        = sat_val(64'(full >>> FRAC_BITS));
         diff_in[k] = 25'(fk) - 25'(feq);
      end
   end

   always_comb begin
      logic signed [47:0] rs, dv;
      rs = 48'($signed({1'b0, rate}));
      for (int k = 0; k < NUM_DIRS; k++) begin
         dv      = 48'($signed(diff_ff[k]));
         d_in[k] = rs * dv;
      end
   end

   always_comb begin
      logic signed [47:0] q;
      logic signed [48:0] r;
      val_type            fk;
      for (int k = 0; k < NUM_DIRS; k++) begin
         fk = c6_ff.f[k];
         q  = $signed(d_ff[k]) >>> FRAC_BITS;
         r  = 49'(fk) - 49'(q);
         res_in.d[k] = c6_ff.solid ? fk : sat_val(64'(r));
      end
      res_in.density = val_type'({1'b0, c6_ff.rho});
      res_in.ux      = c6_ff.ux;
      res_in.uy      = c6_ff.uy;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         c5_ff   <= cell_in;
         diff_ff <= diff_in;
      end
      if (load[1]) begin
         c6_ff <= c5_ff;
         d_ff  <= d_in;
      end
      if (load[2]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== sv/lbm_d2q9_cell_collision_core.sv =====
// Top level of the D2Q9 BGK collision core.
//
//   channel   direction   beat contents
//   req_bus   in          dist_in_0..8, solid
//   rsp_bus   out         dist_out_0..8, density, velocity_x, velocity_y
//   csr_bus   in          relax_rate
//
// One cell enters per cycle unless stalled. Stages: two for moments, 24 for the
// divider (one quotient bit each) and seven for equilibrium and relaxation.
// Synchronous reset empties the pipeline and sets the rate to 1.0.
// Each stage holds its beat while the one after it is full and stalled, so
// bubbles close up and input is taken as long as any stage is free.
module lbm_d2q9_cell_collision_core import d2q9c_pkg::*; #(
   parameter int FRAC_BITS = 20
) (
   input logic         clock,
   input logic         reset,
   d2q9c_req_if.sink   req_bus,
   d2q9c_rsp_if.source rsp_bus,
   d2q9c_csr_if.sink   csr_bus
);

   localparam rate_type RATE_RESET = rate_type'(64'd1 << FRAC_BITS);
   localparam int DIV_BASE = MOM_STAGES;
   localparam int EQ_BASE  = DIV_BASE + QBITS;
   localparam int RLX_BASE = EQ_BASE + EQ_STAGES;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in, adv;
   rate_type               rate_ff, rate_in;

   // A stage may load when the output is taken or this or some later stage is empty.
   for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_adv
      assign adv[i] = rsp_bus.ready || !(&valid_ff[PIPE_STAGES-1:i]);
   end

   assign valid_in = (adv & {valid_ff[PIPE_STAGES-2:0], req_bus.valid}) | (~adv & valid_ff);
   assign rate_in  = csr_bus.valid ? csr_bus.relax_rate : rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rate_ff  <= RATE_RESET;
      end else begin
         valid_ff <= valid_in;
         rate_ff  <= rate_in;
      end
   end

   assign req_bus.ready = adv[0];
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = valid_ff[PIPE_STAGES-1];

   cell_type     cell_req, cell_mom, cell_div, cell_eq;
   div_lane_type mx_lane, my_lane, qx_lane, qy_lane;
   logic [NUM_DIRS-1:0][46:0]           lo_prod;
   logic [NUM_DIRS-1:0][FRAC_BITS+24:0] hi_prod;
   result_type   result;

   always_comb begin
      cell_req.f[0] = req_bus.dist_in_0;
      cell_req.f[1] = req_bus.dist_in_1;
      cell_req.f[2] = req_bus.dist_in_2;
      cell_req.f[3] = req_bus.dist_in_3;
      cell_req.f[4] = req_bus.dist_in_4;
      cell_req.f[5] = req_bus.dist_in_5;
      cell_req.f[6] = req_bus.dist_in_6;
      cell_req.f[7] = req_bus.dist_in_7;
      cell_req.f[8] = req_bus.dist_in_8;
      cell_req.solid = req_bus.solid;
      cell_req.rho   = '0;
      cell_req.ux    = '0;
      cell_req.uy    = '0;
   end

   d2q9c_moments #(.FRAC_BITS(FRAC_BITS)) u_moments (
      .clock    (clock),
      .load     (adv[MOM_STAGES-1:0]),
      .cell_in  (cell_req),
      .cell_out (cell_mom),
      .lane_x   (mx_lane),
      .lane_y   (my_lane)
   );

   d2q9c_divider u_divider (
      .clock    (clock),
      .load     (adv[DIV_BASE +: QBITS]),
      .cell_in  (cell_mom),
      .x_in     (mx_lane),
      .y_in     (my_lane),
      .cell_out (cell_div),
      .x_out    (qx_lane),
      .y_out    (qy_lane)
   );

   d2q9c_equilibrium #(.FRAC_BITS(FRAC_BITS)) u_equilibrium (
      .clock    (clock),
      .load     (adv[EQ_BASE +: EQ_STAGES]),
      .cell_in  (cell_div),
      .x_in     (qx_lane),
      .y_in     (qy_lane),
      .cell_out (cell_eq),
      .lo_out   (lo_prod),
      .hi_out   (hi_prod)
   );

   d2q9c_relax #(.FRAC_BITS(FRAC_BITS)) u_relax (
      .clock    (clock),
      .load     (adv[RLX_BASE +: RLX_STAGES]),
      .rate     (rate_ff),
      .cell_in  (cell_eq),
      .lo_in    (lo_prod),
      .hi_in    (hi_prod),
      .result   (result)
   );

   assign rsp_bus.dist_out_0 = result.d[0];
   assign rsp_bus.dist_out_1 = result.d[1];
   assign rsp_bus.dist_out_2 = result.d[2];
   assign rsp_bus.dist_out_3 = result.d[3];
   assign rsp_bus.dist_out_4 = result.d[4];
   assign rsp_bus.dist_out_5 = result.d[5];
   assign rsp_bus.dist_out_6 = result.d[6];
   assign rsp_bus.dist_out_7 = result.d[7];
   assign rsp_bus.dist_out_8 = result.d[8];
   assign rsp_bus.density    = result.density;
   assign rsp_bus.velocity_x = result.ux;
   assign rsp_bus.velocity_y = result.uy;

endmodule

// ===== sv/d2q9c_checker.sv =====
// Port-level checks of the collision core and their binding to the top level.
`include "lbm_d2q9_cell_collision_core_macros.svh"

module d2q9c_checker import d2q9c_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input val_type density,
   input val_type dist_out_0,
   input val_type velocity_x
);

   // A waiting result stays offered.
   `D2Q9C_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A waiting result keeps its density, dist_out_0 and velocity_x.
   `D2Q9C_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(density) && $stable(dist_out_0) && $stable(velocity_x))

   // The density is floored at one LSB, so it is always positive.
   `D2Q9C_ASSERT_IMP(a_density_pos, clock, reset, rsp_valid, !density[VAL_W-1] && density != '0)

endmodule

bind lbm_d2q9_cell_collision_core d2q9c_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .density    (rsp_bus.density),
   .dist_out_0 (rsp_bus.dist_out_0),
   .velocity_x (rsp_bus.velocity_x)
);

// ===== tb/sv/lbm_d2q9_cell_collision_core_tb.sv =====
// Self-checking testbench of the D2Q9 BGK collision core with its own arithmetic predictor.
module lbm_d2q9_cell_collision_core_tb import d2q9c_pkg::*; ();

   localparam int FB = 20;
   localparam longint ONE = 64'sd1 << FB;
   localparam rate_type RATE_RESET = rate_type'(1 << FB);
   localparam rate_type RATE_MAXV  = 22'h3FFFFF;

   typedef struct {
      val_type f [9];
      logic    solid;
   } cell_in_type;

   typedef struct {
      val_type d [9];
      val_type rho;
      val_type ux;
      val_type uy;
   } cell_out_type;

   // Directed rows: content, and whether the expected result is typed in.
   typedef struct {
      cell_in_type  stim;
      logic         typed;
      cell_out_type res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   d2q9c_req_if req_bus ();
   d2q9c_rsp_if rsp_bus ();
   d2q9c_csr_if csr_bus ();

   lbm_d2q9_cell_collision_core #(.FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rate_type     rate_shadow;
   cell_out_type pending_cells [$];
   int           mismatch_count = 0;
   int           beats_in = 0;
   int           beats_out = 0;
   int           solid_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   const int DX [9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
   const int DY [9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
   const longint WN [9] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

   function automatic longint clamp24(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // Arithmetic shift right is floor division by a power of two.
   function automatic longint floor_sh(input longint x, input int s);
      return x >>> s;
   endfunction

   function automatic cell_out_type collide(input cell_in_type c, input rate_type rate);
      cell_out_type r;
      longint f [9];
      longint rho, mx, my, ux, uy, u2, cu, p, wr, feq, dlt;
      rho = 0; mx = 0; my = 0;
      for (int k = 0; k < 9; k++) begin
         f[k] = longint'(c.f[k]);
         rho += f[k];
         mx += f[k] * DX[k];
         my += f[k] * DY[k];
      end
      if (rho < 1) rho = 1;
      rho = clamp24(rho);
      ux = clamp24((mx * ONE) / rho);
      uy = clamp24((my * ONE) / rho);
      u2 = floor_sh(ux * ux + uy * uy, FB);
      for (int k = 0; k < 9; k++) begin
         if (c.solid) begin
            r.d[k] = c.f[k];
         end else begin
            cu = 3 * (ux * DX[k] + uy * DY[k]);
            p = ONE + cu + floor_sh(cu * cu, FB + 1) - floor_sh(3 * u2, 1);
            wr = (rho * WN[k]) / 36;
            feq = clamp24(floor_sh(wr * p, FB));
            dlt = longint'({1'b0, rate}) * (f[k] - feq);
            r.d[k] = val_type'(clamp24(f[k] - floor_sh(dlt, FB)));
         end
      end
      r.rho = val_type'(rho);
      r.ux = val_type'(ux);
      r.uy = val_type'(uy);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input val_type got, input val_type want);
      $display("mismatch at result %0d: %s got %0d expected %0d", beats_out, what, got, want);
      mismatch_count++;
   endtask

   // Result side: random back-pressure and field-by-field comparison.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cell_out_type want;
      val_type got [9];
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.dist_out_0, rsp_bus.dist_out_1, rsp_bus.dist_out_2,
                 rsp_bus.dist_out_3, rsp_bus.dist_out_4, rsp_bus.dist_out_5,
                 rsp_bus.dist_out_6, rsp_bus.dist_out_7, rsp_bus.dist_out_8};
         if (pending_cells.size() == 0) begin
            report_mismatch("unexpected result beat, density", rsp_bus.density, val_type'(0));
         end else begin
            want = pending_cells.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[k] !== want.d[k]) report_mismatch($sformatf("dist_out_%0d", k),
                                                          got[k], want.d[k]);
            if (rsp_bus.density !== want.rho)
               report_mismatch("density", rsp_bus.density, want.rho);
            if (rsp_bus.velocity_x !== want.ux)
               report_mismatch("velocity_x", rsp_bus.velocity_x, want.ux);
            if (rsp_bus.velocity_y !== want.uy)
               report_mismatch("velocity_y", rsp_bus.velocity_y, want.uy);
         end
         beats_out++;
      end
   end

   // Called at a falling edge; the beat stays offered until a caller idles the channel.
   task automatic send_cell(input cell_in_type c, input cell_out_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.dist_in_0 <= c.f[0]; req_bus.dist_in_1 <= c.f[1]; req_bus.dist_in_2 <= c.f[2];
      req_bus.dist_in_3 <= c.f[3]; req_bus.dist_in_4 <= c.f[4]; req_bus.dist_in_5 <= c.f[5];
      req_bus.dist_in_6 <= c.f[6]; req_bus.dist_in_7 <= c.f[7]; req_bus.dist_in_8 <= c.f[8];
      req_bus.solid <= c.solid;
      do @(posedge clock); while (!req_bus.ready);
      pending_cells.push_back(want);
      beats_in++;
      if (c.solid) solid_count++;
      @(negedge clock);
   endtask

   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_rate(input rate_type v);
      csr_bus.valid <= 1'b1;
      csr_bus.relax_rate <= v;
      do @(posedge clock); while (!csr_bus.ready);
      rate_shadow = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic val_type rand_val(input int spread);
      case ($urandom_range(9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return val_type'($urandom);
         default: return val_type'(int'($urandom_range(2 * spread)) - spread);
      endcase
   endfunction

   // Mostly a cell near rest (each value about its weight times a density near one), else wide random values.
   function automatic cell_in_type rand_cell();
      cell_in_type c;
      int mode;
      mode = $urandom_range(9);
      for (int k = 0; k < 9; k++) begin
         if (mode < 7)
            c.f[k] = val_type'((ONE * WN[k]) / 36 + int'($urandom_range(60000)) - 30000);
         else if (mode < 9)
            c.f[k] = rand_val(4000000);
         else
            c.f[k] = val_type'($urandom);
      end
      c.solid = ($urandom_range(7) == 0);
      return c;
   endfunction

   task automatic random_phase(input int count);
      cell_in_type c;
      for (int i = 0; i < count; i++) begin
         c = rand_cell();
         send_cell(c, collide(c, rate_shadow));
      end
   endtask

   row_type rows [$];

   function automatic row_type mk_row(input val_type v [9], input logic s);
      row_type r;
      r.stim.f = v;
      r.stim.solid = s;
      r.typed = 1'b0;
      return r;
   endfunction

   initial begin
      row_type r;
      val_type v [9];
      cell_out_type want;
      req_bus.valid = 1'b0; req_bus.solid = 1'b0;
      req_bus.dist_in_0 = '0; req_bus.dist_in_1 = '0; req_bus.dist_in_2 = '0;
      req_bus.dist_in_3 = '0; req_bus.dist_in_4 = '0; req_bus.dist_in_5 = '0;
      req_bus.dist_in_6 = '0; req_bus.dist_in_7 = '0; req_bus.dist_in_8 = '0;
      csr_bus.valid = 1'b0; csr_bus.relax_rate = '0;
      rate_shadow = RATE_RESET;

      // All zero: density floors to one LSB and the rest relaxes to zero at rate one.
      v = '{default: val_type'(0)};
      r = mk_row(v, 1'b0);
      r.typed = 1'b1;
      r.res.d = '{default: val_type'(0)};
      r.res.rho = val_type'(1); r.res.ux = '0; r.res.uy = '0;
      rows.push_back(r);
      // Solid all-zero cell passes through.
      r.stim.solid = 1'b1;
      rows.push_back(r);
      v = '{default: VAL_MAX};
      rows.push_back(mk_row(v, 1'b0));
      rows.push_back(mk_row(v, 1'b1));
      v = '{default: VAL_MIN};
      rows.push_back(mk_row(v, 1'b0));
      rows.push_back(mk_row(v, 1'b1));
      // Single directions carry all the mass: large velocities.
      for (int k = 0; k < 9; k++) begin
         v = '{default: val_type'(0)};
         v[k] = val_type'(ONE);
         rows.push_back(mk_row(v, 1'b0));
      end
      v = '{default: val_type'(0)};
      v[1] = VAL_MAX; v[3] = val_type'(-64'sd1);
      rows.push_back(mk_row(v, 1'b0));
      v = '{val_type'(-5), VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, val_type'(1),
            val_type'(-1), VAL_MAX, VAL_MIN};
      rows.push_back(mk_row(v, 1'b0));
      for (int k = 0; k < 9; k++) v[k] = val_type'((ONE * WN[k]) / 36);
      rows.push_back(mk_row(v, 1'b0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         want = rows[i].typed ? rows[i].res : collide(rows[i].stim, rate_shadow);
         send_cell(rows[i].stim, want);
      end
      drain_pipe();

      send_idle_pct = 29; recv_idle_pct = 56;
      write_rate(RATE_MAXV);
      random_phase(300);
      drain_pipe();
      write_rate('0);
      random_phase(300);
      drain_pipe();
      send_idle_pct = 56; recv_idle_pct = 29;
      write_rate(rate_type'(1 << (FB + 1)));
      random_phase(300);
      drain_pipe();
      write_rate(rate_type'($urandom_range(RATE_MAXV)));
      random_phase(300);
      drain_pipe();
      send_idle_pct = 0; recv_idle_pct = 0;
      write_rate(rate_type'(1600000));
      random_phase(300);
      // The sender holds off here until the pipeline has emptied.
      req_bus.valid <= 1'b0;
      while (pending_cells.size() != 0) @(negedge clock);
      write_rate(RATE_RESET);
      random_phase(300);
      drain_pipe();

      $display("%0d cells sent (%0d solid), %0d results checked over six relaxation rates",
               beats_in, solid_count, beats_out);
      if (mismatch_count == 0 && pending_cells.size() == 0) begin
         $display("lbm_d2q9_cell_collision_core_tb: clean");
      end else begin
         $display("lbm_d2q9_cell_collision_core_tb: errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("lbm_d2q9_cell_collision_core_tb: errors");
      $finish;
   end
endmodule
